FILE: design/delta_timeout_queue_assert.svh
// assertion macros for the delta timeout queue
`ifndef DELTA_TIMEOUT_QUEUE_ASSERT_SVH
`define DELTA_TIMEOUT_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every rising clock edge outside reset
`define DTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must never be true outside reset
`define DTQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DTQ_ASSERT(lbl, prop, msg)
`define DTQ_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/dtq_pkg.sv
// shared types, codes and defaults of the delta timeout queue
package dtq_pkg;

  localparam int unsigned DTQ_QUEUE_DEPTH = 16;
  localparam int unsigned DTQ_TIME_WIDTH  = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_ADVANCE = 2'd2
  } dtq_opcode_e;

  typedef enum logic [2:0] {
    ST_EXPIRED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_MISS      = 3'd4,
    ST_NONE      = 3'd5
  } dtq_status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } dtq_alu_op_e;

  typedef struct packed {
    logic        borrow;
    logic        zero;
  } dtq_flags_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay_ticks;
    logic [7:0]  timer_id;
    logic [31:0] elapsed_ticks;
  } dtq_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  expired_id;
    logic        last;
  } dtq_rsp_t;

endpackage

FILE: design/dtq_alu.sv
// shared add / subtract / compare unit of the delta timeout queue
module dtq_alu import dtq_pkg::*; #(
  parameter int unsigned TIME_WIDTH = DTQ_TIME_WIDTH
) (
  input  dtq_alu_op_e             op_i,
  input  logic [TIME_WIDTH-1:0]   a_i,
  input  logic [TIME_WIDTH-1:0]   b_i,
  output logic [TIME_WIDTH-1:0]   res_o,
  output dtq_flags_t              flags_o
);

  logic [TIME_WIDTH:0] wide;

  always_comb begin
    unique case (op_i)
      ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default: wide = {1'b0, a_i};
    endcase
  end

  // borrow flag only meaningful on subtract: set when b > a
  assign res_o          = wide[TIME_WIDTH-1:0];
  assign flags_o.borrow = (op_i == ALU_SUB) && wide[TIME_WIDTH];
  assign flags_o.zero   = (wide[TIME_WIDTH-1:0] == '0);

endmodule

FILE: design/dtq_ram.sv
// entry store of the delta timeout queue, one write and one registered read port
module dtq_ram import dtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DTQ_QUEUE_DEPTH,
  parameter int unsigned TIME_WIDTH  = DTQ_TIME_WIDTH,
  localparam int unsigned AW         = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [TIME_WIDTH-1:0] wdelta_i,
  input  logic [7:0]            wid_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [TIME_WIDTH-1:0] rdelta_o,
  output logic [7:0]            rid_o
);

  logic [TIME_WIDTH-1:0] delta_mem [QUEUE_DEPTH];
  logic [7:0]            id_mem    [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] rdelta_q;
  logic [7:0]            rid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      delta_mem[waddr_i] <= wdelta_i;
      id_mem[waddr_i]    <= wid_i;
    end
    rdelta_q <= delta_mem[raddr_i];
    rid_q    <= id_mem[raddr_i];
  end

  assign rdelta_o = rdelta_q;
  assign rid_o    = rid_q;

endmodule

FILE: design/dtq_seq.sv
// sequencer of the delta timeout queue: inserts, cancels and expires entries by walking and shifting them
module dtq_seq import dtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DTQ_QUEUE_DEPTH,
  parameter int unsigned TIME_WIDTH  = DTQ_TIME_WIDTH,
  localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dtq_req_t      req_i,
  output logic          idle_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dtq_rsp_t      res_o,
  output logic [CW-1:0] level_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_FIX,
    S_INS_SHIFT,
    S_INS_FIXWR,
    S_INS_PUT,
    S_CAN_WALK,
    S_CAN_MERGE,
    S_CAN_SHIFT,
    S_ADV_HEAD,
    S_ADV_SCAN,
    S_ADV_COMP,
    S_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         raddr_q, raddr_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [7:0]            id_q, id_d;
  logic [TIME_WIDTH-1:0] fix_delta_q, fix_delta_d;
  logic [7:0]            fix_id_q, fix_id_d;
  logic [7:0]            pend_q, pend_d;
  dtq_rsp_t              res_q, res_d;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [TIME_WIDTH-1:0] wdelta;
  logic [7:0]            wid;
  logic [TIME_WIDTH-1:0] rdelta;
  logic [7:0]            rid;

  dtq_alu_op_e           alu_op;
  logic [TIME_WIDTH-1:0] alu_a;
  logic [TIME_WIDTH-1:0] alu_b;
  logic [TIME_WIDTH-1:0] alu_res;
  dtq_flags_t            alu_flags;

  logic [CW-1:0]         pos_inc;
  logic [CW-1:0]         ptr_inc;

  assign pos_inc = CW'(pos_q) + CW'(1);
  assign ptr_inc = CW'(ptr_q) + CW'(1);

  dtq_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdelta_i (wdelta),
    .wid_i    (wid),
    .raddr_i  (raddr_d),
    .rdelta_o (rdelta),
    .rid_o    (rid)
  );

  dtq_alu #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  // operand select for the shared unit
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = rdelta;
    alu_b  = rem_q;
    unique case (state_q)
      S_INS_WALK: begin
        alu_a = rem_q;
        alu_b = rdelta;
      end
      S_CAN_MERGE: begin
        alu_op = ALU_ADD;
        alu_b  = fix_delta_q;
      end
      S_ADV_SCAN: alu_b = '0;
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    raddr_d     = raddr_q;
    rem_d       = rem_q;
    id_d        = id_q;
    fix_delta_d = fix_delta_q;
    fix_id_d    = fix_id_q;
    pend_d      = pend_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdelta      = rdelta;
    wid         = rid;
    res_valid_o = 1'b0;
    res_o       = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.opcode)
            OP_INSERT: begin
              rem_d = req_i.delay_ticks[TIME_WIDTH-1:0];
              id_d  = req_i.timer_id;
              if (cnt_q == CW'(QUEUE_DEPTH)) begin
                res_d   = '{status: ST_FULL, expired_id: 8'd0, last: 1'b1};
                state_d = S_EMIT;
              end else if (cnt_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdelta  = req_i.delay_ticks[TIME_WIDTH-1:0];
                wid     = req_i.timer_id;
                cnt_d   = CW'(1);
                res_d   = '{status: ST_INSERTED, expired_id: 8'd0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                raddr_d = '0;
                pos_d   = '0;
                state_d = S_INS_WALK;
              end
            end
            OP_CANCEL: begin
              id_d = req_i.timer_id;
              if (cnt_q == '0) begin
                res_d   = '{status: ST_MISS, expired_id: 8'd0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                raddr_d = '0;
                pos_d   = '0;
                state_d = S_CAN_WALK;
              end
            end
            OP_ADVANCE: begin
              rem_d = req_i.elapsed_ticks[TIME_WIDTH-1:0];
              if (cnt_q == '0) begin
                res_d   = '{status: ST_NONE, expired_id: 8'd0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                raddr_d = '0;
                state_d = S_ADV_HEAD;
              end
            end
            default: ;
          endcase
        end
      end

      // rdelta holds entry pos; skip it while its delta fits in the remainder
      S_INS_WALK: begin
        if (!alu_flags.borrow) begin
          if (pos_inc == cnt_q) begin
            we      = 1'b1;
            waddr   = AW'(pos_inc);
            wdelta  = alu_res;
            wid     = id_q;
            cnt_d   = cnt_q + CW'(1);
            res_d   = '{status: ST_INSERTED, expired_id: 8'd0, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            rem_d   = alu_res;
            pos_d   = pos_q + AW'(1);
            raddr_d = pos_q + AW'(1);
          end
        end else begin
          state_d = S_INS_FIX;
        end
      end

      // follower delta loses the remainder
      S_INS_FIX: begin
        fix_delta_d = alu_res;
        fix_id_d    = rid;
        if (pos_inc == cnt_q) begin
          we      = 1'b1;
          waddr   = AW'(pos_inc);
          wdelta  = alu_res;
          wid     = rid;
          state_d = S_INS_PUT;
        end else begin
          raddr_d = AW'(cnt_q - CW'(1));
          ptr_d   = AW'(cnt_q - CW'(1));
          state_d = S_INS_SHIFT;
        end
      end

      // move entries up by one, top first
      S_INS_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_q + AW'(1);
        if (ptr_inc == pos_inc + CW'(1)) begin
          state_d = S_INS_FIXWR;
        end else begin
          ptr_d   = ptr_q - AW'(1);
          raddr_d = ptr_q - AW'(1);
        end
      end

      S_INS_FIXWR: begin
        we      = 1'b1;
        waddr   = AW'(pos_inc);
        wdelta  = fix_delta_q;
        wid     = fix_id_q;
        state_d = S_INS_PUT;
      end

      S_INS_PUT: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdelta  = rem_q;
        wid     = id_q;
        cnt_d   = cnt_q + CW'(1);
        res_d   = '{status: ST_INSERTED, expired_id: 8'd0, last: 1'b1};
        state_d = S_EMIT;
      end

      S_CAN_WALK: begin
        if (rid == id_q) begin
          if (pos_inc == cnt_q) begin
            cnt_d   = cnt_q - CW'(1);
            res_d   = '{status: ST_CANCELLED, expired_id: 8'd0, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            fix_delta_d = rdelta;
            raddr_d     = pos_q + AW'(1);
            state_d     = S_CAN_MERGE;
          end
        end else if (pos_inc == cnt_q) begin
          res_d   = '{status: ST_MISS, expired_id: 8'd0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          pos_d   = pos_q + AW'(1);
          raddr_d = pos_q + AW'(1);
        end
      end

      // next entry takes the removed delta and drops into its slot
      S_CAN_MERGE: begin
        we     = 1'b1;
        waddr  = pos_q;
        wdelta = alu_res;
        if (pos_inc + CW'(1) == cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = '{status: ST_CANCELLED, expired_id: 8'd0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          ptr_d   = pos_q + AW'(2);
          raddr_d = pos_q + AW'(2);
          state_d = S_CAN_SHIFT;
        end
      end

      S_CAN_SHIFT: begin
        we    = 1'b1;
        waddr = ptr_q - AW'(1);
        if (ptr_inc == cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = '{status: ST_CANCELLED, expired_id: 8'd0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          ptr_d   = ptr_q + AW'(1);
          raddr_d = ptr_q + AW'(1);
        end
      end

      // clamp head at zero: borrow or exact hit both expire it
      S_ADV_HEAD: begin
        if (!(alu_flags.borrow || alu_flags.zero)) begin
          we      = 1'b1;
          waddr   = '0;
          wdelta  = alu_res;
          res_d   = '{status: ST_NONE, expired_id: 8'd0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          pend_d = rid;
          if (cnt_q == CW'(1)) begin
            cnt_d   = '0;
            res_d   = '{status: ST_EXPIRED, expired_id: rid, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            raddr_d = AW'(1);
            ptr_d   = AW'(1);
            state_d = S_ADV_SCAN;
          end
        end
      end

      // pending expiry goes out once we know whether entry ptr is due too
      S_ADV_SCAN: begin
        res_valid_o = 1'b1;
        res_o       = '{status: ST_EXPIRED, expired_id: pend_q, last: !alu_flags.zero};
        if (res_ready_i) begin
          if (alu_flags.zero) begin
            pend_d = rid;
            if (ptr_inc == cnt_q) begin
              cnt_d   = '0;
              res_d   = '{status: ST_EXPIRED, expired_id: rid, last: 1'b1};
              state_d = S_EMIT;
            end else begin
              ptr_d   = ptr_q + AW'(1);
              raddr_d = ptr_q + AW'(1);
            end
          end else begin
            we    = 1'b1;
            waddr = '0;
            if (ptr_inc == cnt_q) begin
              cnt_d   = CW'(1);
              state_d = S_IDLE;
            end else begin
              pos_d   = AW'(1);
              ptr_d   = ptr_q + AW'(1);
              raddr_d = ptr_q + AW'(1);
              state_d = S_ADV_COMP;
            end
          end
        end
      end

      // close the gap left by the expired entries
      S_ADV_COMP: begin
        we    = 1'b1;
        waddr = pos_q;
        if (ptr_inc == cnt_q) begin
          cnt_d   = pos_inc;
          state_d = S_IDLE;
        end else begin
          pos_d   = pos_q + AW'(1);
          ptr_d   = ptr_q + AW'(1);
          raddr_d = ptr_q + AW'(1);
        end
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      ptr_q       <= '0;
      raddr_q     <= '0;
      rem_q       <= '0;
      id_q        <= '0;
      fix_delta_q <= '0;
      fix_id_q    <= '0;
      pend_q      <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      ptr_q       <= ptr_d;
      raddr_q     <= raddr_d;
      rem_q       <= rem_d;
      id_q        <= id_d;
      fix_delta_q <= fix_delta_d;
      fix_id_q    <= fix_id_d;
      pend_q      <= pend_d;
      res_q       <= res_d;
    end
  end

  assign idle_o  = (state_q == S_IDLE);
  assign level_o = cnt_q;

endmodule

FILE: design/delta_timeout_queue.sv
// top level of the delta timeout queue: request intake and output register
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_ready_o    in_req_i   (dtq_req_t)
//   result    out        out_valid_o / out_ready_i  out_rsp_o  (dtq_rsp_t)
//
// one pass of the shared add / subtract unit a cycle; the entry ram has one write and one registered read port
// reset clears the entry count but not the entry ram; contents of slots above the count are never used
// a full output register stalls the expiry scan and the final result
`include "delta_timeout_queue_assert.svh"

module delta_timeout_queue import dtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DTQ_QUEUE_DEPTH,
  parameter int unsigned TIME_WIDTH  = DTQ_TIME_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dtq_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dtq_rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          seq_idle;
  logic          res_valid;
  logic          res_ready;
  dtq_rsp_t      res;
  logic [CW-1:0] level;
  logic          in_accept;
  logic          start_op;

  logic          out_valid_q;
  dtq_rsp_t      out_rsp_q;

  // a new request is taken only while the sequencer sits idle
  assign in_ready_o = seq_idle;
  assign in_accept  = in_valid_i && in_ready_o;

  // accepted request with a defined opcode
  assign start_op = in_accept && (in_req_i.opcode == OP_INSERT ||
                                  in_req_i.opcode == OP_CANCEL ||
                                  in_req_i.opcode == OP_ADVANCE);

  // the sequencer may push when the output slot is empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  dtq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .req_i       (in_req_i),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .level_o     (level)
  );

  // output register parts the sequencer from the result consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_rsp_q   <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // an idle sequencer never offers a result
  `DTQ_NEVER(a_idle_no_result, seq_idle && res_valid, "result offered while idle")
  // entry count stays within the queue depth
  `DTQ_ASSERT(a_level_bound, level <= CW'(QUEUE_DEPTH), "entry count above queue depth")
  // a valid opcode always takes the block busy on the next cycle
  `DTQ_ASSERT(a_busy_after_accept, start_op |=> !in_ready_o, "not busy after request")
  // entry count holds while idle with no request
  `DTQ_ASSERT(a_level_hold, (seq_idle && !in_valid_i) |=> $stable(level), "entry count moved while idle")

endmodule
